// ===== rtl/msgd_pkg.sv =====
// Shared types and constants for the momentum SGD update block.
`default_nettype none
package msgd_pkg;

    localparam int ELEMENTS_DEF = 1024;
    localparam int INDEX_W      = 10;
    localparam int INDEX_SPAN   = 1 << INDEX_W;
    localparam int DATA_W       = 32;
    localparam int COEF_W       = 16;
    localparam int PROD_W       = DATA_W + COEF_W;

    localparam logic [COEF_W-1:0] LR_RESET  = 16'd655;
    localparam logic [COEF_W-1:0] MOM_RESET = 16'd58982;

    localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    typedef enum logic {
        CFG_LR  = 1'b0,
        CFG_MOM = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic               en;
        logic [INDEX_W-1:0] addr;
        logic [DATA_W-1:0]  data;
    } mem_wr_t;

endpackage
`default_nettype wire

// ===== rtl/momentum_sgd_update.sv =====
// Top level: momentum SGD update with configuration registers and velocity store.
// Path: a beat goes through the input, multiply and velocity stages, then the output register.
// Throughput: one beat per cycle while s_ready is high; the velocity read-modify-write
// is forwarded across the multiply and velocity stages, so back-to-back hits on one index
// run at full rate. Reset: config registers take their defaults; the velocity store is then
// zeroed by a sweep over min(ELEMENTS, 1024) entries, during which s_ready stays low.
`default_nettype none
module momentum_sgd_update #(
    parameter int ELEMENTS = msgd_pkg::ELEMENTS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic                                   cfg_index,
    input  wire logic [msgd_pkg::COEF_W-1:0]            cfg_wdata,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [1:0]                             s_command,
    input  wire logic [msgd_pkg::INDEX_W-1:0]           s_index,
    input  wire logic signed [msgd_pkg::DATA_W-1:0]     s_param_value,
    input  wire logic signed [msgd_pkg::DATA_W-1:0]     s_grad_value,
    input  wire logic signed [msgd_pkg::DATA_W-1:0]     s_velocity_value,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [msgd_pkg::DATA_W-1:0]          m_param_out,
    output logic signed [msgd_pkg::DATA_W-1:0]          m_velocity_out,
    output logic                                        m_saturated
);

    localparam int DEPTH = (ELEMENTS < msgd_pkg::INDEX_SPAN) ? ELEMENTS
                                                             : msgd_pkg::INDEX_SPAN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [msgd_pkg::COEF_W-1:0] lr_reg, lr_next;
    logic [msgd_pkg::COEF_W-1:0] mom_reg, mom_next;

    logic                            mem_busy;
    logic                            rd_en;
    logic [msgd_pkg::INDEX_W-1:0]    rd_addr;
    logic [msgd_pkg::DATA_W-1:0]     rd_data;
    msgd_pkg::mem_wr_t               wr;

    always_comb begin
        lr_next  = lr_reg;
        mom_next = mom_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                msgd_pkg::CFG_LR:  lr_next  = cfg_wdata;
                msgd_pkg::CFG_MOM: mom_next = cfg_wdata;
                default: begin
                    lr_next  = lr_reg;
                    mom_next = mom_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg  <= msgd_pkg::LR_RESET;
            mom_reg <= msgd_pkg::MOM_RESET;
        end else begin
            lr_reg  <= lr_next;
            mom_reg <= mom_next;
        end
    end

    msgd_vel_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr),
        .busy    (mem_busy)
    );

    msgd_pipe #(
        .ELEMENTS (ELEMENTS)
    ) u_pipe (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .mem_busy         (mem_busy),
        .lr_coef          (lr_reg),
        .momentum         (mom_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_index          (s_index),
        .s_param_value    (s_param_value),
        .s_grad_value     (s_grad_value),
        .s_velocity_value (s_velocity_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_param_out      (m_param_out),
        .m_velocity_out   (m_velocity_out),
        .m_saturated      (m_saturated),
        .rd_en            (rd_en),
        .rd_addr          (rd_addr),
        .rd_data          (rd_data),
        .wr               (wr)
    );

    a_no_wr_during_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_busy |-> !wr.en)
        else $error("pipeline write during velocity clear");

    a_empty_after_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(mem_busy) |-> !m_valid)
        else $error("result present before any beat could be taken");

    a_sat_has_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
            (m_param_out == $signed(msgd_pkg::S32_MAX) ||
             m_param_out == $signed(msgd_pkg::S32_MIN) ||
             m_velocity_out == $signed(msgd_pkg::S32_MAX) ||
             m_velocity_out == $signed(msgd_pkg::S32_MIN)))
        else $error("saturated flag without a clamped value");

endmodule
`default_nettype wire

// ===== rtl/msgd_vel_mem.sv =====
// Velocity store: single write / single registered read memory with post-reset clear sweep.
`default_nettype none
module msgd_vel_mem #(
    parameter int DEPTH = msgd_pkg::ELEMENTS_DEF,
    parameter int AW    = 10
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               rd_en,
    input  wire logic [msgd_pkg::INDEX_W-1:0]       rd_addr,
    output logic      [msgd_pkg::DATA_W-1:0]        rd_data,
    input  wire msgd_pkg::mem_wr_t                  wr,
    output logic                                    busy
);

    logic [msgd_pkg::DATA_W-1:0] vel_mem [DEPTH];
    logic [msgd_pkg::DATA_W-1:0] rd_data_reg;
    logic [AW:0]                 clr_cnt_reg;
    logic [AW:0]                 clr_cnt_next;

    assign busy    = (clr_cnt_reg != (AW+1)'(DEPTH));
    assign rd_data = rd_data_reg;

    always_comb begin
        clr_cnt_next = clr_cnt_reg;
        if (busy) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy) begin
            vel_mem[clr_cnt_reg[AW-1:0]] <= '0;
        end else if (wr.en) begin
            vel_mem[wr.addr[AW-1:0]] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= vel_mem[rd_addr[AW-1:0]];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/msgd_pipe.sv =====
// Update pipeline: input/read stage, multiply stage, velocity stage, output register.
`default_nettype none
module msgd_pipe #(
    parameter int ELEMENTS = msgd_pkg::ELEMENTS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   mem_busy,
    input  wire logic [msgd_pkg::COEF_W-1:0]            lr_coef,
    input  wire logic [msgd_pkg::COEF_W-1:0]            momentum,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [1:0]                             s_command,
    input  wire logic [msgd_pkg::INDEX_W-1:0]           s_index,
    input  wire logic signed [msgd_pkg::DATA_W-1:0]     s_param_value,
    input  wire logic signed [msgd_pkg::DATA_W-1:0]     s_grad_value,
    input  wire logic signed [msgd_pkg::DATA_W-1:0]     s_velocity_value,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [msgd_pkg::DATA_W-1:0]          m_param_out,
    output logic signed [msgd_pkg::DATA_W-1:0]          m_velocity_out,
    output logic                                        m_saturated,
    output logic                                        rd_en,
    output logic [msgd_pkg::INDEX_W-1:0]                rd_addr,
    input  wire logic [msgd_pkg::DATA_W-1:0]            rd_data,
    output msgd_pkg::mem_wr_t                           wr
);

    localparam int DW = msgd_pkg::DATA_W;
    localparam int IW = msgd_pkg::INDEX_W;
    localparam int PW = msgd_pkg::PROD_W;
    localparam int CW = msgd_pkg::COEF_W;

    typedef struct packed {
        logic [1:0]    cmd;
        logic          ok;
        logic [IW-1:0] idx;
        logic [DW-1:0] param;
        logic [DW-1:0] grad;
        logic [DW-1:0] vel;
    } s0_t;

    typedef struct packed {
        logic [1:0]    cmd;
        logic          ok;
        logic [IW-1:0] idx;
        logic [DW-1:0] param;
        logic [DW-1:0] vel;
        logic [PW-1:0] pa;
        logic [PW-1:0] pb;
    } s1_t;

    typedef struct packed {
        logic [1:0]    cmd;
        logic [IW-1:0] idx;
        logic [DW-1:0] param;
        logic [DW-1:0] vel;
        logic          sat;
        logic          wr;
    } s2_t;

    s0_t s0_reg, s0_next;
    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    logic s0_valid_reg, s0_valid_next;
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic m_valid_reg, m_valid_next;
    logic [DW-1:0] m_param_reg, m_param_next;
    logic [DW-1:0] m_vel_reg, m_vel_next;
    logic          m_sat_reg, m_sat_next;

    logic s0_ready, s1_ready, s2_ready, s3_ready;
    logic accept;
    logic idx_ok;

    logic signed [DW-1:0]   vold;
    logic signed [PW:0]     mul_a;
    logic signed [PW:0]     mul_b;

    logic signed [DW-1:0]   s1_a;
    logic signed [DW-1:0]   s1_b;
    logic        [DW:0]     s1_diff;
    logic                   s1_sat;
    logic        [DW-1:0]   s1_vnew;
    logic                   s1_is_upd;
    logic                   s1_is_load;
    logic        [DW-1:0]   s1_wval;
    logic                   s1_wr;

    logic        [DW:0]     s2_sum;
    logic                   s2_psat;
    logic        [DW-1:0]   s2_pnew;

    assign s3_ready = !m_valid_reg || m_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s0_ready = !s0_valid_reg || s1_ready;
    assign s_ready  = s0_ready && !mem_busy;
    assign accept   = s_valid && s_ready;

    assign idx_ok  = ({{(32-IW){1'b0}}, s_index} < 32'(ELEMENTS));
    assign rd_en   = accept;
    assign rd_addr = s_index;

    // stage 0: capture beat, velocity read in flight
    always_comb begin
        s0_next.cmd   = s_command;
        s0_next.ok    = idx_ok;
        s0_next.idx   = s_index;
        s0_next.param = s_param_value;
        s0_next.grad  = s_grad_value;
        s0_next.vel   = s_velocity_value;
        s0_valid_next = s0_ready ? accept : s0_valid_reg;
    end

    // forward writes not yet seen by the registered read
    always_comb begin
        vold = $signed(rd_data);
        if (s2_valid_reg && s2_reg.wr && (s2_reg.idx == s0_reg.idx)) begin
            vold = $signed(s2_reg.vel);
        end
        if (s1_wr && (s1_reg.idx == s0_reg.idx)) begin
            vold = $signed(s1_wval);
        end
        if (!s0_reg.ok) begin
            vold = '0;
        end
    end

    assign mul_a = vold * $signed({1'b0, momentum});
    assign mul_b = $signed(s0_reg.grad) * $signed({1'b0, lr_coef});

    always_comb begin
        s1_next.cmd   = s0_reg.cmd;
        s1_next.ok    = s0_reg.ok;
        s1_next.idx   = s0_reg.idx;
        s1_next.param = s0_reg.param;
        s1_next.vel   = (s0_reg.cmd == msgd_pkg::CMD_LOAD) ? s0_reg.vel : vold;
        s1_next.pa    = mul_a[PW-1:0];
        s1_next.pb    = mul_b[PW-1:0];
        s1_valid_next = s1_ready ? s0_valid_reg : s1_valid_reg;
    end

    // stage 1: shift, subtract, clamp velocity, write back
    always_comb begin
        s1_a       = $signed(s1_reg.pa[PW-1:CW]);
        s1_b       = $signed(s1_reg.pb[PW-1:CW]);
        s1_diff    = {s1_a[DW-1], s1_a} - {s1_b[DW-1], s1_b};
        s1_sat     = s1_diff[DW] ^ s1_diff[DW-1];
        s1_vnew    = s1_sat ? (s1_diff[DW] ? msgd_pkg::S32_MIN : msgd_pkg::S32_MAX)
                            : s1_diff[DW-1:0];
        s1_is_upd  = (s1_reg.cmd == msgd_pkg::CMD_UPDATE);
        s1_is_load = (s1_reg.cmd == msgd_pkg::CMD_LOAD);
        s1_wval    = s1_is_upd ? s1_vnew : s1_reg.vel;
        s1_wr      = s1_valid_reg && s1_reg.ok && (s1_is_upd || s1_is_load);
    end

    always_comb begin
        wr.en   = s1_wr && s2_ready;
        wr.addr = s1_reg.idx;
        wr.data = s1_wval;
    end

    always_comb begin
        s2_next.cmd   = s1_reg.cmd;
        s2_next.idx   = s1_reg.idx;
        s2_next.param = s1_reg.param;
        s2_next.vel   = s1_wval;
        s2_next.sat   = s1_is_upd && s1_sat;
        s2_next.wr    = s1_reg.ok && (s1_is_upd || s1_is_load);
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
    end

    // stage 2: parameter sum and result select
    always_comb begin
        s2_sum  = {s2_reg.param[DW-1], s2_reg.param} + {s2_reg.vel[DW-1], s2_reg.vel};
        s2_psat = s2_sum[DW] ^ s2_sum[DW-1];
        s2_pnew = s2_psat ? (s2_sum[DW] ? msgd_pkg::S32_MIN : msgd_pkg::S32_MAX)
                          : s2_sum[DW-1:0];
        case (s2_reg.cmd)
            msgd_pkg::CMD_UPDATE: begin
                m_param_next = s2_pnew;
                m_vel_next   = s2_reg.vel;
                m_sat_next   = s2_reg.sat || s2_psat;
            end
            msgd_pkg::CMD_LOAD, msgd_pkg::CMD_READ: begin
                m_param_next = '0;
                m_vel_next   = s2_reg.vel;
                m_sat_next   = 1'b0;
            end
            default: begin
                m_param_next = '0;
                m_vel_next   = '0;
                m_sat_next   = 1'b0;
            end
        endcase
        m_valid_next = s3_ready ? s2_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s0_valid_reg <= s0_valid_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s0_reg <= s0_next;
        end
        if (s0_valid_reg && s1_ready) begin
            s1_reg <= s1_next;
        end
        if (s1_valid_reg && s2_ready) begin
            s2_reg <= s2_next;
        end
        if (s2_valid_reg && s3_ready) begin
            m_param_reg <= m_param_next;
            m_vel_reg   <= m_vel_next;
            m_sat_reg   <= m_sat_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_param_out    = $signed(m_param_reg);
    assign m_velocity_out = $signed(m_vel_reg);
    assign m_saturated    = m_sat_reg;

endmodule
`default_nettype wire
